// File: rtl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg - shared types and constants of the additive feedback generator
// Lag lengths, Lehmer seeding constants, sequencer states and the alphabet
// and index helpers used by the cell chain, the seeding unit and the top level.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned RAW_W         = 31;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned LAG_LEN       = 31;
  localparam int unsigned LAG_SHORT     = 3;
  localparam int unsigned COPY_COUNT    = 3;
  localparam int unsigned SEED_STEPS    = 30;
  localparam int unsigned DISCARD_COUNT = 310;
  localparam int unsigned OUTPUT_COUNT  = 10;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned PROD_W        = 47;

  localparam logic [14:0]      LEHMER_MUL = 15'd16807;
  localparam logic [RAW_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_COPY,
    ST_RUN,
    ST_EMIT
  } afp_state_t;

  typedef enum logic [1:0] {
    SRC_EXT,
    SRC_OLDEST,
    SRC_SUM
  } chain_src_t;

  typedef struct packed {
    logic       shift;
    chain_src_t src;
  } chain_ctl_t;

  // (raw mod 62) = 2*((raw>>1) mod 31) + raw[0]; mod 31 by folding 5-bit chunks
  function automatic logic [IDX_W-1:0] sym_index(input logic [RAW_W-1:0] raw);
    logic [7:0] s;
    logic [5:0] t;
    s = 8'(raw[5:1]) + 8'(raw[10:6]) + 8'(raw[15:11]) + 8'(raw[20:16])
      + 8'(raw[25:21]) + 8'(raw[30:26]);
    t = 6'(s[7:5]) + 6'(s[4:0]);
    if (t >= 6'd31) begin
      t = t - 6'd31;
    end
    return {t[4:0], raw[0]};
  endfunction

  // alphabet order a-z, A-Z, 0-9
  function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] code;
    if (idx < 6'd26) begin
      code = ASCII_LOWER_A + 7'(idx);
    end else if (idx < 6'd52) begin
      code = ASCII_UPPER_A + 7'(idx - 6'd26);
    end else begin
      code = ASCII_ZERO + 7'(idx - 6'd52);
    end
    return code;
  endfunction

endpackage

// File: rtl/afp_cell.sv
// ----------------------------------------------------------------------------
// afp_cell - one word of the lag line
// Holds one 32-bit generator word and takes the word on its input on a shift:
// its neighbour's word, or the feedback word for cell 0.
module afp_cell
  import afp_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [WORD_W-1:0] d,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// File: rtl/afp_chain.sv
// ----------------------------------------------------------------------------
// afp_chain - lag line of 31 cells with additive feedback
// Cell 0 holds the newest word r[i-1], the last cell the oldest r[i-31].
// The word shifted in is an external word, the oldest word, or the sum
// r[i-31] + r[i-3] with 32-bit wrap.
// ----------------------------------------------------------------------------
module afp_chain
  import afp_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [WORD_W-1:0] ext_data,
  output logic [WORD_W-1:0] head,
  output logic [WORD_W-1:0] sum
);

  logic [WORD_W-1:0] q   [LAG_LEN];
  logic [WORD_W-1:0] feed;

  assign sum  = q[LAG_LEN-1] + q[LAG_SHORT-1];
  assign head = q[0];

  always_comb begin
    case (ctl.src)
      SRC_EXT:    feed = ext_data;
      SRC_OLDEST: feed = q[LAG_LEN-1];
      SRC_SUM:    feed = sum;
      default:    feed = sum;
    endcase
  end

  for (genvar i = 0; i < LAG_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      afp_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d     (feed),
        .q     (q[i])
      );
    end else begin : g_body
      afp_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d     (q[i-1]),
        .q     (q[i])
      );
    end
  end

endmodule

// File: rtl/afp_lehmer.sv
// ----------------------------------------------------------------------------
// afp_lehmer - seeding step r = 16807 * r mod (2^31 - 1)
// The product is registered; the reduction folds the bits above bit 30 back
// in and takes one conditional subtract of the modulus.
// ----------------------------------------------------------------------------
module afp_lehmer
  import afp_pkg::*;
(
  input  logic              clk,
  input  logic              mul_en,
  input  logic [WORD_W-1:0] x,
  output logic [WORD_W-1:0] y
);

  logic [PROD_W-1:0] prod_r;
  logic [WORD_W-1:0] fold;
  logic [RAW_W-1:0]  red;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(x) * PROD_W'(LEHMER_MUL);
    end
  end

  // 2^31 is 1 mod the modulus, and the fold stays below twice the modulus
  assign fold = WORD_W'(prod_r[RAW_W-1:0]) + WORD_W'(prod_r[PROD_W-1:RAW_W]);

  always_comb begin
    if (fold >= WORD_W'(LEHMER_MOD)) begin
      red = RAW_W'(fold - WORD_W'(LEHMER_MOD));
    end else begin
      red = fold[RAW_W-1:0];
    end
  end

  assign y = WORD_W'(red);

endmodule

// File: rtl/additive_feedback_prng_string.sv
// ----------------------------------------------------------------------------
// additive_feedback_prng_string - seeded additive feedback string generator
// Turns one 32-bit seed into a string of alphanumeric characters.
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transaction carries a seed in in_tdata[31:0]; in_tready is
//           high only while the generator is idle, so one seed is worked on
//           at a time
//   out_* : ten transactions per seed, one character each; out_tlast marks
//           the tenth
// sequence: the seed enters the lag line in the accept cycle, then 30 seeding
//   words each take a multiply step and then a reduce step, then 3 copy steps
//   and 310 discarded steps follow; the characters then follow one per cycle
//   while out_tready stays high, and the generator is ready again the cycle
//   after the last character is loaded
// reset: rst_n low returns the sequencer to idle and drops out_tvalid; the
//   lag line holds no reset value and is fully rewritten by every seed
// stall: a result waits in the output register while out_tready is low and
//   the generator holds its lag line until that register frees up
// ----------------------------------------------------------------------------
module additive_feedback_prng_string
  import afp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [6:0] char_code, [12:7] symbol_index,
                                  // [43:13] raw_value, [47:44] zero
  output logic        out_tlast   // last
);

  afp_state_t        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r;
  logic [RAW_W-1:0]  out_raw_r;

  chain_ctl_t        chain_ctl;
  logic [WORD_W-1:0] chain_head;
  logic [WORD_W-1:0] chain_sum;
  logic [WORD_W-1:0] ext_data;
  logic [WORD_W-1:0] lehmer_y;
  logic              mul_en;
  logic              emit_go;
  logic              emit_last;
  logic [IDX_W-1:0]  out_idx;

  afp_chain u_chain (
    .clk      (clk),
    .ctl      (chain_ctl),
    .ext_data (ext_data),
    .head     (chain_head),
    .sum      (chain_sum)
  );

  afp_lehmer u_lehmer (
    .clk    (clk),
    .mul_en (mul_en),
    .x      (chain_head),
    .y      (lehmer_y)
  );

  assign ext_data  = (st_r == ST_IDLE) ? in_tdata : lehmer_y;
  assign in_tready = (st_r == ST_IDLE);
  assign emit_go   = (st_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = (cnt_r == CNT_W'(OUTPUT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    mul_en          = 1'b0;
    chain_ctl.shift = 1'b0;
    chain_ctl.src   = SRC_SUM;
    unique case (st_r)
      ST_IDLE: begin
        chain_ctl.src = SRC_EXT;
        if (in_tvalid) begin
          chain_ctl.shift = 1'b1;
          cnt_nxt         = '0;
          st_nxt          = ST_SEED_MUL;
        end
      end
      ST_SEED_MUL: begin
        mul_en = 1'b1;
        st_nxt = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        chain_ctl.shift = 1'b1;
        chain_ctl.src   = SRC_EXT;
        if (cnt_r == CNT_W'(SEED_STEPS - 1)) begin
          cnt_nxt = '0;
          st_nxt  = ST_COPY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = ST_SEED_MUL;
        end
      end
      ST_COPY: begin
        // r[31..33] repeat r[0..2]
        chain_ctl.shift = 1'b1;
        chain_ctl.src   = SRC_OLDEST;
        if (cnt_r == CNT_W'(COPY_COUNT - 1)) begin
          cnt_nxt = '0;
          st_nxt  = ST_RUN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
        chain_ctl.shift = 1'b1;
        if (cnt_r == CNT_W'(DISCARD_COUNT - 1)) begin
          cnt_nxt = '0;
          st_nxt  = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          chain_ctl.shift = 1'b1;
          if (emit_last) begin
            cnt_nxt = '0;
            st_nxt  = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_raw_r  <= chain_sum[WORD_W-1:1];
      out_last_r <= emit_last;
    end
  end

  assign out_idx    = sym_index(out_raw_r);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_raw_r, out_idx, sym_char(out_idx)};

  // a seed transaction always starts the seeding multiply
  a_seed_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r == ST_SEED_MUL))
    else $error("seed transaction did not start seeding");

  // every reduce cycle follows a multiply cycle
  a_red_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SEED_RED) |-> ($past(st_r) == ST_SEED_MUL))
    else $error("reduce step without a registered product");

  // discard counter stays in range
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (cnt_r < CNT_W'(DISCARD_COUNT)))
    else $error("discard counter out of range");

  // the last character returns the sequencer to idle with tlast set
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && emit_last) |=> ((st_r == ST_IDLE) && out_tvalid && out_tlast))
    else $error("last character did not end the string");

  // a new character is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit_go)
    else $error("output register overwritten while stalled");

endmodule
